[design/rfm_pkg.sv]
// ----------------------------------------------------------------------------
// rfm_pkg: shared types and constants of the reciprocal frequency meter
// Register codes, field widths, defaults and the types that pass between units.
// ----------------------------------------------------------------------------
package rfm_pkg;

  localparam int AveragePeriodsDefault = 10;
  localparam int FractionBitsDefault   = 8;

  localparam int CountW   = 32;
  localparam int FreqW    = 40;
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 40;
  localparam int QueueDepth = 2;

  localparam logic [CountW-1:0] TimerHzReset   = 32'd1000000;
  localparam logic [FreqW-1:0]  StopThrReset   = 40'd2560;
  localparam logic [FreqW-1:0]  StartThrReset  = 40'd3072;
  localparam logic [CountW-1:0] TimeoutReset   = 32'd100000;
  localparam logic [FreqW-1:0]  FreqMax        = {FreqW{1'b1}};

  typedef enum logic [CfgAddrW-1:0] {
    CfgTimerHz  = 3'd0,
    CfgStopThr  = 3'd1,
    CfgStartThr = 3'd2,
    CfgTimeout  = 3'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CountW-1:0] timer_hz;
    logic [FreqW-1:0]  stop_thr;
    logic [FreqW-1:0]  start_thr;
    logic [CountW-1:0] timeout;
  } cfg_t;

  // one measurement as handed from the front to the back
  typedef struct packed {
    logic [CountW-1:0] span;   // newest minus oldest edge, wrapped
    logic [CountW-1:0] since;  // counts since the newest edge, wrapped
  } meas_t;

endpackage

[design/rfm_queue.sv]
// ----------------------------------------------------------------------------
// rfm_queue: measurement queue
// Small first-in first-out buffer between the capture front and the divider.
// ----------------------------------------------------------------------------
module rfm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rfm_pkg::meas_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rfm_pkg::meas_t pop_data_o
);
  import rfm_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  meas_t            entry_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  fill_q, fill_d;

  assign full_o     = (fill_q == CntW'(QueueDepth));
  assign valid_o    = (fill_q != '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/rfm_front.sv]
// ----------------------------------------------------------------------------
// rfm_front: capture front end
// Stores edge timestamps in the ring and turns measure requests into spans.
// ----------------------------------------------------------------------------
module rfm_front #(
  parameter int AVERAGE_PERIODS = rfm_pkg::AveragePeriodsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      action_i,
  input  logic [rfm_pkg::CountW-1:0] count_value_i,
  output logic                      push_o,
  output rfm_pkg::meas_t            push_data_o,
  input  logic                      full_i
);
  import rfm_pkg::*;

  localparam int Depth = AVERAGE_PERIODS + 1;
  localparam int PosW  = $clog2(Depth);

  typedef enum logic {
    FrIdle,
    FrPush
  } fr_state_e;

  fr_state_e         state_q;
  logic [PosW-1:0]   pos_q;
  logic [Depth-1:0]  valid_q;
  logic [CountW-1:0] ring_q [Depth];
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] rd_new_q, rd_old_q;
  logic              rd_new_vld_q, rd_old_vld_q;
  logic [PosW-1:0]   newest_idx;
  logic [CountW-1:0] newest, oldest;
  logic              accept, capture, measure;

  assign in_ready_o = (state_q == FrIdle) && !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign capture    = accept && !action_i;
  assign measure    = accept && action_i;
  assign newest_idx = (pos_q == '0) ? PosW'(Depth - 1) : pos_q - 1'b1;

  // entries never written read as the cleared value
  assign newest = rd_new_vld_q ? rd_new_q : '0;
  assign oldest = rd_old_vld_q ? rd_old_q : '0;

  assign push_o            = (state_q == FrPush);
  assign push_data_o.span  = newest - oldest;
  assign push_data_o.since = count_q - newest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      pos_q   <= '0;
      valid_q <= '0;
    end else begin
      unique case (state_q)
        FrIdle: begin
          if (capture) begin
            valid_q[pos_q] <= 1'b1;
            pos_q <= (pos_q == PosW'(Depth - 1)) ? '0 : pos_q + 1'b1;
          end
          if (measure) begin
            state_q <= FrPush;
          end
        end
        FrPush: begin
          state_q <= FrIdle;
        end
        default: state_q <= FrIdle;
      endcase
    end
  end

  // ring storage, registered read of newest and oldest edge
  always_ff @(posedge clk_i) begin
    if (capture) begin
      ring_q[pos_q] <= count_value_i;
    end
    if (measure) begin
      count_q      <= count_value_i;
      rd_new_q     <= ring_q[newest_idx];
      rd_old_q     <= ring_q[pos_q];
      rd_new_vld_q <= valid_q[newest_idx];
      rd_old_vld_q <= valid_q[pos_q];
    end
  end

endmodule

[design/rfm_back.sv]
// ----------------------------------------------------------------------------
// rfm_back: divider back end
// Averages the span, divides the timer rate by it and runs the stopped flag.
// ----------------------------------------------------------------------------
module rfm_back #(
  parameter int AVERAGE_PERIODS = rfm_pkg::AveragePeriodsDefault,
  parameter int FRACTION_BITS   = rfm_pkg::FractionBitsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rfm_pkg::cfg_t             cfg_i,
  input  logic                      q_valid_i,
  input  rfm_pkg::meas_t            q_data_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rfm_pkg::FreqW-1:0] frequency_o,
  output logic                      stopped_o
);
  import rfm_pkg::*;

  localparam int DivW     = CountW + FRACTION_BITS;
  localparam int CntW     = $clog2(DivW + 1);
  localparam int ProdW    = 2 * CountW;
  // span / AVERAGE_PERIODS as (span * (2^32 + AvgRecipLo)) >> AvgShift, exact for 32 bits
  localparam int AvgShift = CountW + $clog2(AVERAGE_PERIODS);
  localparam logic [ProdW-1:0] AvgRecip =
    ((ProdW'(1) << AvgShift) + ProdW'(AVERAGE_PERIODS - 1)) / ProdW'(AVERAGE_PERIODS);
  localparam logic [CountW-1:0] AvgRecipLo = AvgRecip[CountW-1:0];

  typedef enum logic [1:0] {
    BkIdle,
    BkAvg,
    BkFreq,
    BkDone
  } bk_state_e;

  bk_state_e         state_q;
  logic [DivW-1:0]   dq_q;       // dividend in, quotient out
  logic [CountW-1:0] rem_q;
  logic [CountW-1:0] divisor_q;
  logic [CntW-1:0]   cnt_q;
  logic [CountW-1:0] since_q;
  logic [CountW-1:0] span_q;
  logic [ProdW-1:0]  prod_q;
  logic [FreqW-1:0]  freq_q;
  logic              flag_q;
  logic              out_valid_q;
  logic [FreqW-1:0]  out_freq_q;
  logic              out_stopped_q;

  logic [CountW:0]   rem_ext;
  logic [CountW+1:0] trial;
  logic              ge;
  logic [CountW-1:0] rem_next;
  logic [DivW-1:0]   dq_next;
  logic [ProdW-1:0]  prod;
  logic [ProdW:0]    avg_sum;
  logic [CountW-1:0] avg;
  logic              out_free;
  logic              out_valid_d;
  logic              flag_d;
  logic              sat;

  // one restoring step per cycle
  assign rem_ext  = {rem_q, dq_q[DivW-1]};
  assign trial    = {1'b0, rem_ext} - {2'b00, divisor_q};
  assign ge       = !trial[CountW+1];
  assign rem_next = ge ? trial[CountW-1:0] : rem_ext[CountW-1:0];
  assign dq_next  = {dq_q[DivW-2:0], ge};
  assign sat      = |(dq_q >> FreqW);

  // average by reciprocal: multiply at pop, add the implicit top bit in the cycle after
  assign prod    = {{CountW{1'b0}}, q_data_i.span} * {{CountW{1'b0}}, AvgRecipLo};
  assign avg_sum = {1'b0, span_q, {CountW{1'b0}}} + {1'b0, prod_q};
  assign avg     = CountW'(avg_sum >> AvgShift);

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_d = ((state_q == BkDone) && out_free) ? 1'b1
                                                         : (out_valid_q && !out_ready_i);
  assign q_pop_o     = (state_q == BkIdle) && q_valid_i;

  always_comb begin
    flag_d = flag_q;
    if (flag_q) begin
      if (freq_q >= cfg_i.start_thr) begin
        flag_d = 1'b0;
      end
    end else if ((freq_q < cfg_i.stop_thr) || (since_q >= cfg_i.timeout)) begin
      flag_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frequency_o = out_freq_q;
  assign stopped_o   = out_stopped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        BkIdle: begin
          if (q_valid_i) begin
            state_q <= BkAvg;
          end
        end
        BkAvg: begin
          cnt_q   <= CntW'(DivW);
          state_q <= (avg == '0) ? BkDone : BkFreq;
        end
        BkFreq: begin
          if (cnt_q == '0) begin
            state_q <= BkDone;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        BkDone: begin
          if (out_free) begin
            flag_q  <= flag_d;
            state_q <= BkIdle;
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BkIdle: begin
        span_q  <= q_data_i.span;
        prod_q  <= prod;
        since_q <= q_data_i.since;
      end
      BkAvg: begin
        divisor_q <= avg;
        dq_q      <= DivW'(cfg_i.timer_hz) << FRACTION_BITS;
        rem_q     <= '0;
        freq_q    <= FreqMax;  // zero average period saturates
      end
      BkFreq: begin
        if (cnt_q == '0) begin
          freq_q <= sat ? FreqMax : FreqW'(dq_q);
        end else begin
          dq_q  <= dq_next;
          rem_q <= rem_next;
        end
      end
      BkDone: begin
        if (out_free) begin
          out_freq_q    <= flag_d ? '0 : freq_q;
          out_stopped_q <= flag_d;
        end
      end
      default: ;
    endcase
  end

endmodule

[design/reciprocal_frequency_meter_core.sv]
// ----------------------------------------------------------------------------
// reciprocal_frequency_meter_core: reciprocal frequency meter
// Edge timestamps fill a ring; a measure request yields frequency and stopped.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid_i/in_ready_o, action_i, count_value_i | capture or measure
//  out     | out_valid_o/out_ready_i, frequency_o, stopped_o | one per measure
//  cfg     | cfg_we_i, cfg_addr_i, cfg_wdata_i        | register write
//
//  a capture is written to the ring at once; a measure holds the input off for the ring read
//  per measure the back end runs these steps in order:
//  pop and multiply, finish the average by reciprocal,
//  radix-2 division for the frequency, hand off
//  a two-entry queue lets captures go on meanwhile; a stalled output holds the back end
//  reset clears the ring valid bits, position and stopped flag and loads the register defaults at once
// ----------------------------------------------------------------------------
module reciprocal_frequency_meter_core #(
  parameter int AVERAGE_PERIODS = rfm_pkg::AveragePeriodsDefault,
  parameter int FRACTION_BITS   = rfm_pkg::FractionBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         action_i,
  input  logic [rfm_pkg::CountW-1:0]   count_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [rfm_pkg::FreqW-1:0]    frequency_o,
  output logic                         stopped_o,
  input  logic                         cfg_we_i,
  input  logic [rfm_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [rfm_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rfm_pkg::*;

  cfg_t  cfg_q;
  logic  q_push, q_full, q_pop, q_valid;
  meas_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_hz  <= TimerHzReset;
      cfg_q.stop_thr  <= StopThrReset;
      cfg_q.start_thr <= StartThrReset;
      cfg_q.timeout   <= TimeoutReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CfgTimerHz:  cfg_q.timer_hz  <= cfg_wdata_i[CountW-1:0];
        CfgStopThr:  cfg_q.stop_thr  <= cfg_wdata_i[FreqW-1:0];
        CfgStartThr: cfg_q.start_thr <= cfg_wdata_i[FreqW-1:0];
        CfgTimeout:  cfg_q.timeout   <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  rfm_front #(
    .AVERAGE_PERIODS(AVERAGE_PERIODS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .count_value_i(count_value_i),
    .push_o       (q_push),
    .push_data_o  (q_wdata),
    .full_i       (q_full)
  );

  rfm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_data_o (q_rdata)
  );

  rfm_back #(
    .AVERAGE_PERIODS(AVERAGE_PERIODS),
    .FRACTION_BITS  (FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .frequency_o(frequency_o),
    .stopped_o  (stopped_o)
  );

`ifndef ASSERT_OFF
  a_stopped_reads_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stopped_o |-> frequency_o == '0)
    else $error("stopped result carries a nonzero frequency");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("measurement pushed into a full queue");

  a_measure_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && action_i |=> !in_ready_o && q_push)
    else $error("measure transfer did not reach the queue on the next cycle");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the reciprocal frequency meter core
// Drives capture and measure transfers under random bursts and output stalls,
// predicts each reading from a shadow edge ring and register set, and checks
// every output transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rfm_pkg::*;

  localparam int AveragePeriods = AveragePeriodsDefault;
  localparam int FractionBits   = FractionBitsDefault;
  localparam int RingDepth      = AveragePeriods + 1;
  localparam int DrainCycles    = 120;
  localparam int CycleLimit     = 1_000_000;
  localparam int PhaseCount     = 8;
  localparam int PhaseItems     = 135;

  localparam logic ActCapture = 1'b0;
  localparam logic ActMeasure = 1'b1;
  localparam logic [CfgAddrW-1:0] CfgUnmapped = 3'd7;

  typedef struct {
    logic [FreqW-1:0] frequency;
    logic             stopped;
  } reading_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_ready_o;
  logic                in_action;
  logic [CountW-1:0]   in_count;
  logic                out_valid_o;
  logic                out_ready;
  logic [FreqW-1:0]    frequency_o;
  logic                stopped_o;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CfgDataW-1:0] cfg_wdata;

  reciprocal_frequency_meter_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .action_i     (in_action),
    .count_value_i(in_count),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .frequency_o  (frequency_o),
    .stopped_o    (stopped_o),
    .cfg_we_i     (cfg_we),
    .cfg_addr_i   (cfg_addr),
    .cfg_wdata_i  (cfg_wdata)
  );

  // shadow of the block state
  logic [CountW-1:0] edge_ring [RingDepth];
  int unsigned       ring_wr;
  logic              held_stopped;
  cfg_t              meter_cfg;
  reading_t          reading_q [$];

  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned sink_left;
  int unsigned sink_mode;

  // stimulus generator state
  logic [CountW-1:0] gen_edge;
  logic [CountW-1:0] gen_base;
  logic [CountW-1:0] gen_jitter;
  logic [CountW-1:0] gen_timeout;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("status: fail");
    $finish;
  end

  function automatic void predict_reading(logic act, logic [CountW-1:0] cnt);
    logic [CountW-1:0] newest;
    logic [CountW-1:0] oldest;
    logic [CountW-1:0] avg;
    logic [CountW-1:0] since;
    logic [63:0]       quot;
    logic [FreqW-1:0]  freq;
    reading_t          rd;
    if (act == ActCapture) begin
      edge_ring[ring_wr] = cnt;
      ring_wr = (ring_wr + 1) % RingDepth;
      return;
    end
    newest = edge_ring[(ring_wr == 0) ? RingDepth - 1 : ring_wr - 1];
    oldest = edge_ring[ring_wr];
    avg    = (newest - oldest) / 32'(AveragePeriods);
    since  = cnt - newest;
    if (avg == '0) begin
      freq = FreqMax;
    end else begin
      quot = (64'(meter_cfg.timer_hz) << FractionBits) / 64'(avg);
      freq = (quot > 64'(FreqMax)) ? FreqMax : quot[FreqW-1:0];
    end
    if (held_stopped) begin
      if (freq >= meter_cfg.start_thr) held_stopped = 1'b0;
    end else if (freq < meter_cfg.stop_thr || since >= meter_cfg.timeout) begin
      held_stopped = 1'b1;
    end
    rd.frequency = held_stopped ? '0 : freq;
    rd.stopped   = held_stopped;
    reading_q.push_back(rd);
  endfunction

  // one input transfer; valid stays up across a burst
  task automatic send_item(input logic act, input logic [CountW-1:0] cnt);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_action <= act;
    in_count  <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    predict_reading(act, cnt);
  endtask

  // drop valid, wait for every reading, then let the back end go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (reading_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] addr, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (addr)
      CfgTimerHz:  meter_cfg.timer_hz  = data[CountW-1:0];
      CfgStopThr:  meter_cfg.stop_thr  = data[FreqW-1:0];
      CfgStartThr: meter_cfg.start_thr = data[FreqW-1:0];
      CfgTimeout:  meter_cfg.timeout   = data[CountW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // empty ring averages to zero: saturated frequency, timeout, recovery
  task automatic test_empty_ring();
    send_item(ActMeasure, '0);
    send_item(ActMeasure, '1);
    send_item(ActMeasure, 32'h0000_0001);
  endtask

  // 10 Hz edges straddle the stop threshold, a faster timer clears the flag
  task automatic test_hysteresis();
    logic [CountW-1:0] last;
    last = 32'hFFFA_0000;
    for (int i = 0; i < RingDepth; i++) begin
      last = 32'hFFFA_0000 + 32'(i) * 32'd100000;  // wraps past zero
      send_item(ActCapture, last);
    end
    send_item(ActMeasure, last + 32'd50);
    last = last + 32'd100010;
    send_item(ActCapture, last);
    send_item(ActMeasure, last + 32'd50);
    settle_block();
    write_reg(CfgTimerHz, 40'd1250000);
    send_item(ActMeasure, last + 32'd99);
  endtask

  task automatic test_register_edges();
    settle_block();
    write_reg(CfgTimerHz, '0);
    send_item(ActMeasure, 32'd7);
    settle_block();
    write_reg(CfgTimerHz, 40'd1300000);
    write_reg(CfgTimeout, '0);
    send_item(ActMeasure, 32'd7);
    send_item(ActMeasure, 32'd8);
    settle_block();
    write_reg(CfgUnmapped, {8'($urandom), 32'($urandom)});
    // upper bits beyond the register width are dropped
    write_reg(CfgTimerHz, 40'hAB_000F_4240);
    write_reg(CfgStopThr, '0);
    write_reg(CfgStartThr, FreqMax);
    write_reg(CfgTimeout, 40'hFF_FFFF_FFFF);
    send_item(ActMeasure, '1);
  endtask

  task automatic test_random_traffic();
    logic [CountW-1:0] timer;
    logic [CountW-1:0] since;
    logic [63:0]       scaled;
    logic [63:0]       wide;
    logic [FreqW-1:0]  stop;
    logic [FreqW-1:0]  start;
    logic [FreqW-1:0]  swap;
    logic              drift_up;
    int unsigned       pick;
    for (int p = 0; p < PhaseCount; p++) begin
      settle_block();
      pick = $urandom_range(0, 7);
      if (pick == 0) gen_base = $urandom_range(0, 12);  // averages down to zero
      else if (pick == 1) gen_base = $urandom;
      else gen_base = $urandom_range(16, 400000);
      gen_jitter = gen_base >> 3;
      case ($urandom_range(0, 7))
        0: timer = 32'd1;
        1: timer = '1;
        default: timer = $urandom_range(1000, 50_000_000);
      endcase
      // thresholds placed around the edge rate so the flag keeps toggling
      scaled = 64'(timer) << FractionBits;
      stop   = 40'(scaled / (64'(gen_base) + 64'(gen_base >> 4) + 64'd1));
      wide   = 64'(stop) + (64'(stop) >> $urandom_range(2, 5));
      start  = (wide > 64'(FreqMax)) ? FreqMax : wide[FreqW-1:0];
      case ($urandom_range(0, 9))
        0: stop = '0;
        1: stop = FreqMax;
        2: start = '0;
        3: start = FreqMax;
        4: begin
          swap  = stop;
          stop  = start;
          start = swap;
        end
        default: ;
      endcase
      wide = 64'(gen_base) * 64'($urandom_range(1, 3)) + 64'd1;
      gen_timeout = (wide > 64'hFFFF_FFFF) ? '1 : wide[CountW-1:0];
      case ($urandom_range(0, 7))
        0: gen_timeout = 32'd1;
        1: gen_timeout = '1;
        default: ;
      endcase
      write_reg(CfgTimerHz, 40'(timer));
      write_reg(CfgStopThr, stop);
      write_reg(CfgStartThr, start);
      write_reg(CfgTimeout, 40'(gen_timeout));
      write_reg(CfgUnmapped - 3'($urandom_range(0, 3)), {8'($urandom), 32'($urandom)});
      gen_edge = $urandom;
      drift_up = $urandom_range(0, 1);
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 24 == 23) begin
          gen_base = drift_up ? gen_base + (gen_base >> 4) : gen_base - (gen_base >> 4);
          if ($urandom_range(0, 2) == 0) drift_up = ~drift_up;
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          send_item(1'($urandom), $urandom);
        end else if (pick < 60) begin
          if ($urandom_range(0, 1) == 1) gen_edge = gen_edge + gen_base
                                                    + $urandom_range(0, gen_jitter);
          else gen_edge = gen_edge + gen_base - $urandom_range(0, gen_jitter);
          send_item(ActCapture, gen_edge);
        end else if (pick < 65) begin
          gen_edge = gen_edge + $urandom;  // broken edge sequence
          send_item(ActCapture, gen_edge);
        end else begin
          case ($urandom_range(0, 3))
            0: since = $urandom_range(0, gen_base);
            1: since = gen_timeout - 32'd1;
            2: since = gen_timeout;
            default: since = $urandom;
          endcase
          send_item(ActMeasure, gen_edge + since);
        end
      end
    end
  endtask

  // output side stalls in stretches of its own
  always @(posedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_left <= $urandom_range(4, 40);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (reading_q.size() == 0) begin
        $error("unexpected transfer: frequency %0d stopped %0d", frequency_o, stopped_o);
        error_count++;
      end else begin
        want = reading_q.pop_front();
        if (frequency_o !== want.frequency) begin
          $error("frequency: expected %0d, actual %0d", want.frequency, frequency_o);
          error_count++;
        end
        if (stopped_o !== want.stopped) begin
          $error("stopped: expected %0d, actual %0d", want.stopped, stopped_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid    <= 1'b0;
    in_action   <= ActCapture;
    in_count    <= '0;
    out_ready   <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_addr    <= CfgTimerHz;
    cfg_wdata   <= '0;
    cycle_count = 0;
    error_count = 0;
    burst_left  = 0;
    sink_left   = 0;
    sink_mode   = 0;
    for (int i = 0; i < RingDepth; i++) edge_ring[i] = '0;
    ring_wr      = 0;
    held_stopped = 1'b0;
    meter_cfg.timer_hz  = TimerHzReset;
    meter_cfg.stop_thr  = StopThrReset;
    meter_cfg.start_thr = StartThrReset;
    meter_cfg.timeout   = TimeoutReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_ring();
    test_hysteresis();
    test_register_edges();
    test_random_traffic();
    settle_block();

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
